FILE: sv/drtfl_pkg.sv
// Shared definitions for the dated rate table: field widths, status codes,
// date checks and tree sizing helpers.
// Depends on nothing; every other file imports it.
package drtfl_pkg;

	// Field widths of the request and response transactions.
	localparam int YEAR_W   = 14;
	localparam int MD_W     = 7;
	localparam int RATE_W   = 48;
	localparam int AMT_W    = 27;
	localparam int STATUS_W = 3;
	localparam int PROD_W   = 64;

	// Date key is year, month (4 bits) and day (5 bits) packed together.
	localparam int MON_KEY_W = 4;
	localparam int DAY_KEY_W = 5;
	localparam int KEY_W     = YEAR_W + MON_KEY_W + DAY_KEY_W;

	// Fixed point split of the rate and the amount.
	localparam int FRAC_W    = 16;
	localparam int RATE_HI_W = RATE_W - FRAC_W;
	localparam int AMT_MAG_W = AMT_W - 1;

	localparam int DEPTH_DEF = 1024;
	localparam int FAN       = 32;

	localparam logic [AMT_W-1:0] AMOUNT_LIMIT = AMT_W'(1000 << FRAC_W);

	// Calendar limits.
	localparam logic [YEAR_W-1:0] YEAR_MAX  = YEAR_W'(9999);
	localparam logic [MD_W-1:0]   MONTH_MAX = MD_W'(12);
	localparam logic [MD_W-1:0]   FEB       = MD_W'(2);
	localparam logic [MD_W-1:0]   APR       = MD_W'(4);
	localparam logic [MD_W-1:0]   JUN       = MD_W'(6);
	localparam logic [MD_W-1:0]   SEP       = MD_W'(9);
	localparam logic [MD_W-1:0]   NOV       = MD_W'(11);
	localparam logic [MD_W-1:0]   DAYS_LEAP = MD_W'(29);
	localparam logic [MD_W-1:0]   DAYS_FEB  = MD_W'(28);
	localparam logic [MD_W-1:0]   DAYS_30   = MD_W'(30);
	localparam logic [MD_W-1:0]   DAYS_31   = MD_W'(31);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_BAD_DATE   = 3'd1,
		ST_NEG_AMOUNT = 3'd2,
		ST_BIG_AMOUNT = 3'd3,
		ST_NO_RATE    = 3'd4,
		ST_FULL       = 3'd5
	} status_t;

	// Update commands broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic ovr;
	} cell_ctl_t;

	// What a cell offers to the selection tree: the floor entry's rate, and
	// whether that entry carries exactly the searched date.
	typedef struct packed {
		logic              dup;
		logic [RATE_W-1:0] rate;
	} leaf_t;

	// Node count at a given level of the selection tree.
	function automatic int level_width(input int n, input int l);
		int w;
		w = n;
		for (int i = 0; i < l; i++) begin
			w = (w + FAN - 1) / FAN;
		end
		return w;
	endfunction

	// Number of registered levels needed to reduce n leaves to one node.
	function automatic int tree_levels(input int n);
		int w;
		int lv;
		w  = n;
		lv = 0;
		while (w > 1) begin
			w  = (w + FAN - 1) / FAN;
			lv = lv + 1;
		end
		return (lv < 1) ? 1 : lv;
	endfunction

	// Calendar check; February has 29 days whenever the year is a multiple of 4.
	function automatic logic date_ok(input logic [YEAR_W-1:0] y, input logic [MD_W-1:0] m,
			input logic [MD_W-1:0] d);
		logic [MD_W-1:0] last;
		logic            ok;
		if (m == FEB) begin
			last = (y[1:0] == 2'b00) ? DAYS_LEAP : DAYS_FEB;
		end else if (m == APR || m == JUN || m == SEP || m == NOV) begin
			last = DAYS_30;
		end else begin
			last = DAYS_31;
		end
		ok = (y <= YEAR_MAX) && (m >= MD_W'(1)) && (m <= MONTH_MAX) &&
			(d >= MD_W'(1)) && (d <= last);
		return ok;
	endfunction

	function automatic logic [KEY_W-1:0] make_key(input logic [YEAR_W-1:0] y,
			input logic [MD_W-1:0] m, input logic [MD_W-1:0] d);
		return {y, m[MON_KEY_W-1:0], d[DAY_KEY_W-1:0]};
	endfunction

endpackage

FILE: sv/drtfl_if.sv
// Request and response channel interfaces of the dated rate table.
// Depends on drtfl_pkg for the field widths.
interface drtfl_req_if import drtfl_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [YEAR_W-1:0]        year;
	logic [MD_W-1:0]          month;
	logic [MD_W-1:0]          day;
	logic [RATE_W-1:0]        rate_in;
	logic signed [AMT_W-1:0]  amount;

	modport source(output valid, cmd, year, month, day, rate_in, amount, input ready);
	modport sink(input valid, cmd, year, month, day, rate_in, amount, output ready);
endinterface

interface drtfl_rsp_if import drtfl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PROD_W-1:0]   product;

	modport source(output valid, status, product, input ready);
	modport sink(input valid, status, product, output ready);
endinterface

FILE: sv/drtfl_cell.sv
// One cell of the sorted rate chain: holds one dated entry, compares it with
// the broadcast date and shifts toward its right neighbor on insertion.
// Depends on drtfl_pkg.
module drtfl_cell import drtfl_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 11
) (
	input  logic              clk,
	input  logic [KEY_W-1:0]  new_key,
	input  logic [RATE_W-1:0] new_rate,
	input  logic [CNT_W-1:0]  count,
	input  cell_ctl_t         ctl,
	input  logic [KEY_W-1:0]  left_key,
	input  logic [RATE_W-1:0] left_rate,
	input  logic              left_gt,
	input  logic              right_le,
	output logic [KEY_W-1:0]  key,
	output logic [RATE_W-1:0] rate,
	output logic              gt,
	output logic              le,
	output leaf_t             leaf
);

	logic [KEY_W-1:0]  key_q;
	logic [RATE_W-1:0] rate_q;
	logic              occ;
	logic              eq;
	logic              sel;
	logic              take;

	// The entry is live when this slot lies below the fill count.
	assign occ = CNT_W'(IDX) < count;
	assign gt  = occ && (key_q > new_key);
	assign le  = occ && (key_q <= new_key);
	assign eq  = occ && (key_q == new_key);

	// The last entry not after the date is the floor; only it drives the tree.
	assign sel       = le && !right_le;
	assign leaf.rate = sel ? rate_q : '0;
	assign leaf.dup  = sel && eq;

	// Later entries shift right by one, and the first free slot is filled too.
	assign take = ctl.ins && (gt || (CNT_W'(IDX) == count));

	always_ff @(posedge clk) begin
		if (take) begin
			if (left_gt) begin
				key_q  <= left_key;
				rate_q <= left_rate;
			end else begin
				key_q  <= new_key;
				rate_q <= new_rate;
			end
		end else if (ctl.ovr && eq) begin
			rate_q <= new_rate;
		end
	end

	assign key  = key_q;
	assign rate = rate_q;

endmodule

FILE: sv/drtfl_tree.sv
// Registered OR tree that gathers the single selected cell's offer into one
// node, FAN inputs per node and one register level per stage.
// Depends on drtfl_pkg.
module drtfl_tree import drtfl_pkg::*; #(
	parameter int N = DEPTH_DEF
) (
	input  logic  clk,
	input  leaf_t leaf [N],
	output leaf_t root
);

	localparam int LEVELS = tree_levels(N);
	localparam int W1     = level_width(N, 1);

	leaf_t lvl_s [LEVELS][W1];

	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		localparam int WP = level_width(N, l);
		localparam int WC = level_width(N, l + 1);
		for (genvar i = 0; i < W1; i++) begin : g_node
			if (i < WC) begin : g_used
				leaf_t part [FAN];
				leaf_t sum;

				// Gather this node's children; missing children read as zero.
				for (genvar k = 0; k < FAN; k++) begin : g_child
					if (i * FAN + k < WP) begin : g_src
						if (l == 0) begin : g_leaf
							assign part[k] = leaf[i * FAN + k];
						end else begin : g_inner
							assign part[k] = lvl_s[l - 1][i * FAN + k];
						end
					end else begin : g_none
						assign part[k] = '0;
					end
				end

				// At most one child is nonzero, so an OR selects it.
				always_comb begin
					sum = '0;
					for (int k = 0; k < FAN; k++) begin
						sum = sum | part[k];
					end
				end

				always_ff @(posedge clk) begin
					lvl_s[l][i] <= sum;
				end
			end else begin : g_unused
				always_ff @(posedge clk) begin
					lvl_s[l][i] <= '0;
				end
			end
		end
	end

	assign root = lvl_s[LEVELS - 1][0];

endmodule

FILE: sv/dated_rate_table_floor_lookup.sv
// Dated rate table with floor lookup.
// Request channel (req): cmd selects a load of rate_in at a date or a query
// of amount at a date. Response channel (rsp): one transaction per request,
// carrying status and product (amount times the floor rate, Q48.16).
// Entries live in a row of TABLE_DEPTH cells kept sorted by date; a load
// shifts later entries one cell to the right or overwrites a matching date.
// Each cell compares its date with the request, and a registered OR tree of
// LEVELS = ceil(log32(TABLE_DEPTH)) stages (2 at the default depth) picks
// the floor entry's rate.
// One request is worked at a time: the block waits in S_TREE while the
// floor entry passes the tree, decides and multiplies in S_APPLY, adds in
// S_SUM and loads the output register, then goes back to idle to take the
// next request.
// The response sits in an output register; the block waits there only when
// a new response is ready and the previous one has not been taken.
// Reset empties the table (the fill count goes to zero) and drops any
// pending response; no clearing pass is needed.
// Depends on drtfl_pkg, drtfl_if, drtfl_cell and drtfl_tree.
module dated_rate_table_floor_lookup import drtfl_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	drtfl_req_if.sink    req,
	drtfl_rsp_if.source  rsp
);

	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int LEVELS = tree_levels(TABLE_DEPTH);
	localparam int WAIT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TREE,
		S_APPLY,
		S_SUM
	} state_t;

	state_t               state_q;
	logic [WAIT_W-1:0]    wait_q;
	logic [CNT_W-1:0]     count_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [PROD_W-1:0]    out_product_q;

	// Request held for the duration of its work.
	logic                 cmd_q;
	logic [YEAR_W-1:0]    year_q;
	logic [MD_W-1:0]      month_q;
	logic [MD_W-1:0]      day_q;
	logic [RATE_W-1:0]    rate_in_q;
	logic [AMT_W-1:0]     amount_q;
	logic [KEY_W-1:0]     key;

	logic [KEY_W-1:0]     cell_key  [TABLE_DEPTH];
	logic [RATE_W-1:0]    cell_rate [TABLE_DEPTH];
	logic                 cell_gt   [TABLE_DEPTH];
	logic                 cell_le   [TABLE_DEPTH];
	leaf_t                leaf      [TABLE_DEPTH];
	leaf_t                root;
	cell_ctl_t            ctl;
	status_t              status_c;

	status_t                          status_s1;
	logic [AMT_MAG_W+RATE_HI_W-1:0]   mul_hi_s1;
	logic [AMT_MAG_W+FRAC_W-1:0]      mul_lo_s1;
	logic [PROD_W-1:0]                product_c;
	logic                             accept;
	logic                             out_free;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign key      = make_key(year_q, month_q, day_q);

	// Capture the request transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= req.cmd;
			year_q    <= req.year;
			month_q   <= req.month;
			day_q     <= req.day;
			rate_in_q <= req.rate_in;
			amount_q  <= $unsigned(req.amount);
		end
	end

	// Row of cells, each handing its entry to the right on insertion.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0]  lk;
		logic [RATE_W-1:0] lr;
		logic              lg;
		logic              rl;
		if (i == 0) begin : g_first
			assign lk = '0;
			assign lr = '0;
			assign lg = 1'b0;
		end else begin : g_left
			assign lk = cell_key[i - 1];
			assign lr = cell_rate[i - 1];
			assign lg = cell_gt[i - 1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign rl = 1'b0;
		end else begin : g_right
			assign rl = cell_le[i + 1];
		end
		drtfl_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.new_key   (key),
			.new_rate  (rate_in_q),
			.count     (count_q),
			.ctl       (ctl),
			.left_key  (lk),
			.left_rate (lr),
			.left_gt   (lg),
			.right_le  (rl),
			.key       (cell_key[i]),
			.rate      (cell_rate[i]),
			.gt        (cell_gt[i]),
			.le        (cell_le[i]),
			.leaf      (leaf[i])
		);
	end

	drtfl_tree #(
		.N (TABLE_DEPTH)
	) u_tree (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	// Decide the outcome once the floor entry has come out of the tree.
	always_comb begin
		status_c = ST_OK;
		ctl      = '0;
		priority if (!date_ok(year_q, month_q, day_q)) begin
			status_c = ST_BAD_DATE;
		end else if (cmd_q == CMD_LOAD) begin
			priority if (root.dup) begin
				ctl.ovr = 1'b1;
			end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
				status_c = ST_FULL;
			end else begin
				ctl.ins = 1'b1;
			end
		end else if (amount_q[AMT_W-1]) begin
			status_c = ST_NEG_AMOUNT;
		end else if (amount_q > AMOUNT_LIMIT) begin
			status_c = ST_BIG_AMOUNT;
		end else if (!cell_le[0]) begin
			status_c = ST_NO_RATE;
		end
		if (state_q != S_APPLY) begin
			ctl = '0;
		end
	end

	// Split the product into two narrow multiplies, registered once while the
	// outcome is decided, so that a stalled response keeps its values.
	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) begin
			status_s1 <= status_c;
			mul_hi_s1 <= (AMT_MAG_W + RATE_HI_W)'(amount_q[AMT_MAG_W-1:0]) *
				(AMT_MAG_W + RATE_HI_W)'(root.rate[RATE_W-1:FRAC_W]);
			mul_lo_s1 <= (AMT_MAG_W + FRAC_W)'(amount_q[AMT_MAG_W-1:0]) *
				(AMT_MAG_W + FRAC_W)'(root.rate[FRAC_W-1:0]);
		end
	end

	assign product_c = (status_s1 == ST_OK && cmd_q == CMD_QUERY) ?
		PROD_W'(mul_hi_s1) + PROD_W'(mul_lo_s1 >> FRAC_W) : '0;

	// Sequencer, fill count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			wait_q        <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= '0;
			out_product_q <= '0;
		end else begin
			// A taken response empties the output register unless the next
			// response moves in at the same edge.
			if (out_valid_q && rsp.ready && state_q != S_SUM) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						wait_q  <= '0;
						state_q <= S_TREE;
					end
				end
				S_TREE: begin
					wait_q <= wait_q + WAIT_W'(1);
					if (wait_q == WAIT_W'(LEVELS - 1)) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (ctl.ins) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= status_s1;
						out_product_q <= product_c;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.product = out_product_q;

endmodule

FILE: sv/drtfl_chk.sv
// Port-level checks of the dated rate table, attached to the top level by
// the bind statement at the end of this file.
// Depends on drtfl_pkg and dated_rate_table_floor_lookup.
module drtfl_chk import drtfl_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [PROD_W-1:0]   rsp_product
);

	// Every response carries a defined status code.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status <= ST_FULL))
		else $error("response status out of range");

	// Only a successful transaction may produce a nonzero product.
	a_product_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != ST_OK) |-> (rsp_product == '0))
		else $error("nonzero product on a failed transaction");

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
		$stable(rsp_product)))
		else $error("response changed while stalled");

	// One request at a time: no request is taken right after another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in progress");

endmodule

bind dated_rate_table_floor_lookup drtfl_chk u_drtfl_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_product (rsp.product)
);

FILE: sim/dated_rate_table_floor_lookup_test.sv
// Self-checking testbench for the dated rate table with floor lookup.
// Drives loads and queries through a shadow table and compares every response.
// Depends on drtfl_pkg, drtfl_if and dated_rate_table_floor_lookup.
`timescale 1ns / 1ps

module dated_rate_table_floor_lookup_test;
	import drtfl_pkg::*;

	localparam int TABLE_DEPTH  = DEPTH_DEF;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 150;

	localparam logic [AMT_W-1:0]  AMT_ONE   = AMT_W'(1 << FRAC_W);
	localparam logic [AMT_W-1:0]  AMT_MINUS = '1;
	localparam logic [RATE_W-1:0] RATE_ONE  = RATE_W'(1 << FRAC_W);

	// Idling patterns applied to the request and response channels.
	typedef enum int {
		PACE_NONE,
		PACE_SEND,
		PACE_RECV,
		PACE_BOTH
	} pace_t;

	typedef struct {
		logic              cmd;
		logic [YEAR_W-1:0] year;
		logic [MD_W-1:0]   month;
		logic [MD_W-1:0]   day;
		logic [RATE_W-1:0] rate;
		logic [AMT_W-1:0]  amount;
	} rate_req_t;

	typedef struct {
		status_t           status;
		logic [PROD_W-1:0] product;
	} rate_rsp_t;

	typedef struct {
		rate_req_t req;
		bit        typed;
		rate_rsp_t rsp;
	} directed_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	drtfl_req_if req();
	drtfl_rsp_if rsp();

	dated_rate_table_floor_lookup #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	// Shadow copy of the sorted table, and responses still owed by the block.
	logic [KEY_W-1:0]  shadow_key[$];
	logic [RATE_W-1:0] shadow_rate[$];
	rate_rsp_t         owed_results[$];
	directed_row_t     directed_rows[$];

	pace_t pace        = PACE_NONE;
	int    failures    = 0;
	int    holds_asked = 0;
	int    holds_done  = 0;

	// Length of a month, or zero when the month does not exist.
	function automatic int month_days(input logic [YEAR_W-1:0] y, input logic [MD_W-1:0] m);
		int n;
		case (m)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 31;
			7'd4, 7'd6, 7'd9, 7'd11: n = 30;
			7'd2: n = (y % 4 == 0) ? 29 : 28;
			default: n = 0;
		endcase
		return n;
	endfunction

	function automatic bit calendar_ok(input logic [YEAR_W-1:0] y, input logic [MD_W-1:0] m,
			input logic [MD_W-1:0] d);
		return (y <= 9999) && (d >= 1) && (int'(d) <= month_days(y, m));
	endfunction

	// Applies one transaction to the shadow table and returns the response it owes.
	function automatic rate_rsp_t price_item(input rate_req_t r);
		rate_rsp_t        o;
		logic [KEY_W-1:0] k;
		int               pos;
		int               idx;
		logic [79:0]      wide;
		o.status  = ST_OK;
		o.product = '0;
		if (!calendar_ok(r.year, r.month, r.day)) begin
			o.status = ST_BAD_DATE;
		end else begin
			k   = {r.year, r.month[3:0], r.day[4:0]};
			pos = 0;
			while (pos < shadow_key.size() && shadow_key[pos] < k) pos++;
			if (r.cmd == CMD_LOAD) begin
				if (pos < shadow_key.size() && shadow_key[pos] == k) begin
					shadow_rate[pos] = r.rate;
				end else if (shadow_key.size() >= TABLE_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					shadow_key.insert(pos, k);
					shadow_rate.insert(pos, r.rate);
				end
			end else if (r.amount[AMT_W-1]) begin
				o.status = ST_NEG_AMOUNT;
			end else if (r.amount > AMOUNT_LIMIT) begin
				o.status = ST_BIG_AMOUNT;
			end else begin
				// Exact date match wins; otherwise take the latest earlier date.
				idx = (pos < shadow_key.size() && shadow_key[pos] == k) ? pos : pos - 1;
				if (idx < 0) begin
					o.status = ST_NO_RATE;
				end else begin
					wide      = 80'(r.amount) * 80'(shadow_rate[idx]);
					o.product = wide[79:16];
				end
			end
		end
		return o;
	endfunction

	task automatic pick_date(output logic [YEAR_W-1:0] y, output logic [MD_W-1:0] m,
			output logic [MD_W-1:0] d);
		y = ($urandom_range(0, 3) == 0) ? YEAR_W'($urandom_range(1990, 2030))
			: YEAR_W'($urandom_range(0, 9999));
		m = MD_W'($urandom_range(1, 12));
		d = MD_W'($urandom_range(1, month_days(y, m)));
	endtask

	// Mostly well-formed loads and queries, with some raw noise on every field.
	task automatic random_item(output rate_req_t r);
		int               pick;
		int               idx;
		logic [KEY_W-1:0] k;
		pick     = $urandom_range(0, 99);
		r.rate   = {16'($urandom()), 32'($urandom())};
		r.amount = AMT_W'($urandom());
		if (pick < 12) begin
			r.cmd   = 1'($urandom());
			r.year  = YEAR_W'($urandom());
			r.month = MD_W'($urandom());
			r.day   = MD_W'($urandom());
		end else begin
			r.cmd = (pick < 55) ? CMD_LOAD : CMD_QUERY;
			if (shadow_key.size() != 0 && $urandom_range(0, 3) == 0) begin
				idx     = $urandom_range(0, shadow_key.size() - 1);
				k       = shadow_key[idx];
				r.year  = k[KEY_W-1:9];
				r.month = MD_W'(k[8:5]);
				r.day   = MD_W'(k[4:0]);
			end else begin
				pick_date(r.year, r.month, r.day);
			end
			if ($urandom_range(0, 1) == 0) r.rate = RATE_W'($urandom_range(0, 20 << FRAC_W));
			case ($urandom_range(0, 7))
				0: r.amount = AMT_W'($urandom());
				1: r.amount = AMT_W'(int'(AMOUNT_LIMIT) + $urandom_range(0, 4) - 2);
				2: r.amount = AMT_W'($urandom_range(0, 16'hFFFF));
				default: r.amount = AMT_W'($urandom_range(0, int'(AMOUNT_LIMIT)));
			endcase
		end
	endtask

	// Offers one request transaction and records what it owes once accepted.
	task automatic offer(input rate_req_t r, input bit typed, input rate_rsp_t typed_rsp);
		rate_rsp_t predicted;
		int        gap_pct;
		gap_pct = (pace == PACE_SEND) ? 60 : (pace == PACE_BOTH) ? 26 : 0;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
		req.valid   <= 1'b1;
		req.cmd     <= r.cmd;
		req.year    <= r.year;
		req.month   <= r.month;
		req.day     <= r.day;
		req.rate_in <= r.rate;
		req.amount  <= r.amount;
		do @(posedge clk); while (!req.ready);
		predicted = price_item(r);
		owed_results.push_back(typed ? typed_rsp : predicted);
	endtask

	task automatic add_row(input logic cmd, input int y, input int m, input int d,
			input logic [RATE_W-1:0] rate, input logic [AMT_W-1:0] amt, input bit typed,
			input status_t st, input logic [PROD_W-1:0] prod);
		directed_row_t row;
		row.req = '{cmd, YEAR_W'(y), MD_W'(m), MD_W'(d), rate, amt};
		row.typed = typed;
		row.rsp = '{st, prod};
		directed_rows.push_back(row);
	endtask

	// Response side: random stalls, plus one long hold-off on request.
	initial begin : rsp_pacing
		int stall_pct;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				stall_pct = (pace == PACE_RECV) ? 60 : (pace == PACE_BOTH) ? 26 : 0;
				rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Compare each response transaction with the oldest one owed.
	always @(posedge clk) begin
		rate_rsp_t due;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (owed_results.size() == 0) begin
				$error("unexpected response: status %0d product %0h", rsp.status, rsp.product);
				failures++;
			end else begin
				due = owed_results.pop_front();
				if (rsp.status !== due.status) begin
					$error("status: expected %0d, got %0d", due.status, rsp.status);
					failures++;
				end
				if (rsp.product !== due.product) begin
					$error("product: expected %0h, got %0h", due.product, rsp.product);
					failures++;
				end
			end
		end
	end

	// End the run when no transaction moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
			else quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		rate_req_t r;
		rate_rsp_t none;
		none = '{ST_OK, '0};
		req.valid   <= 1'b0;
		req.cmd     <= CMD_LOAD;
		req.year    <= '0;
		req.month   <= '0;
		req.day     <= '0;
		req.rate_in <= '0;
		req.amount  <= '0;

		// Directed rows: calendar edges, field extremes and the check order.
		add_row(CMD_QUERY, 2024, 6, 15, '0, AMT_ONE, 1, ST_NO_RATE, '0);
		add_row(CMD_LOAD, 1900, 2, 29, 3 * RATE_ONE, '0, 1, ST_OK, '0);
		add_row(CMD_LOAD, 2001, 2, 29, RATE_ONE, '0, 1, ST_BAD_DATE, '0);
		add_row(CMD_LOAD, 2000, 2, 29, RATE_ONE, '0, 1, ST_OK, '0);
		add_row(CMD_LOAD, 2000, 2, 30, RATE_ONE, '0, 1, ST_BAD_DATE, '0);
		add_row(CMD_LOAD, 2023, 4, 31, RATE_ONE, '0, 1, ST_BAD_DATE, '0);
		add_row(CMD_LOAD, 2023, 4, 30, 48'h18000, '0, 1, ST_OK, '0);
		add_row(CMD_LOAD, 2023, 0, 10, RATE_ONE, '0, 1, ST_BAD_DATE, '0);
		add_row(CMD_LOAD, 2023, 13, 10, RATE_ONE, '0, 1, ST_BAD_DATE, '0);
		add_row(CMD_LOAD, 2023, 5, 0, RATE_ONE, '0, 1, ST_BAD_DATE, '0);
		add_row(CMD_LOAD, 10000, 1, 1, RATE_ONE, '0, 1, ST_BAD_DATE, '0);
		add_row(CMD_LOAD, 16383, 127, 127, '1, '1, 1, ST_BAD_DATE, '0);
		add_row(CMD_QUERY, 1899, 12, 31, '0, AMT_ONE, 1, ST_NO_RATE, '0);
		add_row(CMD_LOAD, 0, 1, 1, '1, '0, 1, ST_OK, '0);
		add_row(CMD_LOAD, 9999, 12, 31, '0, '0, 1, ST_OK, '0);
		add_row(CMD_QUERY, 2000, 2, 29, '0, AMOUNT_LIMIT, 1, ST_OK, PROD_W'(AMOUNT_LIMIT));
		add_row(CMD_QUERY, 2000, 2, 29, '0, AMOUNT_LIMIT + 1, 1, ST_BIG_AMOUNT, '0);
		add_row(CMD_QUERY, 2000, 2, 29, '0, 27'h3FFFFFF, 1, ST_BIG_AMOUNT, '0);
		add_row(CMD_QUERY, 2000, 2, 29, '0, AMT_MINUS, 1, ST_NEG_AMOUNT, '0);
		add_row(CMD_QUERY, 2000, 2, 29, '0, 27'h4000000, 1, ST_NEG_AMOUNT, '0);
		add_row(CMD_QUERY, 2001, 2, 29, '0, AMT_MINUS, 1, ST_BAD_DATE, '0);
		add_row(CMD_QUERY, 1800, 1, 1, '0, AMT_MINUS, 1, ST_NEG_AMOUNT, '0);
		add_row(CMD_QUERY, 0, 1, 1, '0, AMOUNT_LIMIT, 0, ST_OK, '0);
		add_row(CMD_LOAD, 2000, 2, 29, 48'h28000, AMT_MINUS, 1, ST_OK, '0);
		add_row(CMD_QUERY, 2010, 7, 4, '1, 2 * AMT_ONE, 0, ST_OK, '0);
		add_row(CMD_QUERY, 9999, 12, 31, '0, AMOUNT_LIMIT, 1, ST_OK, '0);
		add_row(CMD_QUERY, 2023, 6, 1, '0, '0, 1, ST_OK, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
		end

		// Random traffic under each idling pattern; the first one also stalls
		// the response side long enough to back up the request channel.
		for (int p = PACE_NONE; p <= PACE_BOTH; p++) begin
			pace = pace_t'(p);
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				if (pace == PACE_NONE && i == RANDOM_ITEMS / 2) holds_asked++;
				random_item(r);
				offer(r, 0, none);
			end
		end
		req.valid <= 1'b0;

		while (owed_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (failures == 0 && owed_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/drtfl_pkg.sv
sv/drtfl_if.sv
sv/drtfl_cell.sv
sv/drtfl_tree.sv
sv/dated_rate_table_floor_lookup.sv
sv/drtfl_chk.sv
sim/dated_rate_table_floor_lookup_test.sv
